FILE: design/tisd_pkg.sv
// shared types, codes and tables for the terminal input sequence decoder
package tisd_pkg;

	localparam int PARAM_CAPACITY = 32;
	localparam int PCNT_W = $clog2(PARAM_CAPACITY + 1);

	localparam logic [2:0] K_TEXT   = 3'd0;
	localparam logic [2:0] K_KEY    = 3'd1;
	localparam logic [2:0] K_MOUSE  = 3'd2;
	localparam logic [2:0] K_PBEGIN = 3'd3;
	localparam logic [2:0] K_PBYTE  = 3'd4;
	localparam logic [2:0] K_PEND   = 3'd5;
	localparam logic [2:0] K_FIN    = 3'd6;
	localparam logic [2:0] K_FOUT   = 3'd7;

	localparam logic [31:0] SK_UP     = 32'h0011_0000;
	localparam logic [31:0] SK_DOWN   = 32'h0011_0001;
	localparam logic [31:0] SK_RIGHT  = 32'h0011_0002;
	localparam logic [31:0] SK_LEFT   = 32'h0011_0003;
	localparam logic [31:0] SK_HOME   = 32'h0011_0004;
	localparam logic [31:0] SK_END    = 32'h0011_0005;
	localparam logic [31:0] SK_INSERT = 32'h0011_0006;
	localparam logic [31:0] SK_DELETE = 32'h0011_0007;
	localparam logic [31:0] SK_PGUP   = 32'h0011_0008;
	localparam logic [31:0] SK_PGDN   = 32'h0011_0009;

	localparam logic [2:0] MOD_SHIFT = 3'd1;
	localparam logic [2:0] MOD_ALT   = 3'd2;
	localparam logic [2:0] MOD_CTRL  = 3'd4;

	localparam logic [7:0] B_ESC = 8'h1b;
	localparam logic [2:0] MARKER_LEN = 3'd6;

	typedef enum logic [4:0] {
		M_GROUND = 5'b00001,
		M_ESC    = 5'b00010,
		M_CSI    = 5'b00100,
		M_SS3    = 5'b01000,
		M_PASTE  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [2:0]  flush_cnt;
		logic        main_vld;
		logic [2:0]  kind;
		logic [31:0] key_code;
		logic [31:0] modifiers;
		logic [7:0]  text_byte;
		logic [14:0] mouse_x;
		logic [14:0] mouse_y;
		logic [2:0]  mouse_button;
		logic [2:0]  mouse_action;
	} desc_t;

	function automatic logic [7:0] end_marker(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h1b;
			3'd1: r = 8'h5b;
			3'd2: r = 8'h32;
			3'd3: r = 8'h30;
			3'd4: r = 8'h31;
			3'd5: r = 8'h7e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: design/terminal_input_sequence_decoder.sv
// top level of the terminal input sequence decoder
//  channel | signals                       | direction
//  input   | in_valid, in_ready, in_byte   | byte in
//  output  | out_valid, out_ready, fields  | decoded items out
// one byte is accepted per cycle while the result register can take it; each
// is decoded in a single pass between the input register and the result register
// a byte giving n items holds the result register until all n are taken (up to 6,
// on a failed paste end marker match); most bytes give zero or one
// reset returns to ground mode with all parse state cleared
// stalls on the output side back up through the input register
module terminal_input_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] key_code,
	output logic [31:0] modifiers,
	output logic [7:0]  text_byte,
	output logic [14:0] mouse_x,
	output logic [14:0] mouse_y,
	output logic [2:0]  mouse_button,
	output logic [2:0]  mouse_action,
	output logic        last
);
	import tisd_pkg::*;

	desc_t desc;
	logic  desc_vld;
	logic  take;

	tisd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.desc_vld (desc_vld),
		.desc     (desc)
	);

	tisd_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_vld     (desc_vld),
		.desc         (desc),
		.take         (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.key_code     (key_code),
		.modifiers    (modifiers),
		.text_byte    (text_byte),
		.mouse_x      (mouse_x),
		.mouse_y      (mouse_y),
		.mouse_button (mouse_button),
		.mouse_action (mouse_action),
		.last         (last)
	);

endmodule

FILE: design/tisd_parser.sv
// input register, sequence state and one-pass decode of each byte
module tisd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               take,
	output logic               desc_vld,
	output tisd_pkg::desc_t    desc
);
	import tisd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	mode_t              mode_q, mode_d;
	logic [2:0]         marker_q, marker_d;
	logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
	logic [1:0]         field_q, field_d;
	logic               sub_q, sub_d;
	logic               mpre_q, mpre_d;
	logic [31:0]        v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;

	assign adv = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_GROUND;
			marker_q <= '0;
			pcnt_q <= '0;
			field_q <= '0;
			sub_q <= 1'b0;
			mpre_q <= 1'b0;
			v1_q <= '0;
			v2_q <= '0;
			v3_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			marker_q <= marker_d;
			pcnt_q <= pcnt_d;
			field_q <= field_d;
			sub_q <= sub_d;
			mpre_q <= mpre_d;
			v1_q <= v1_d;
			v2_q <= v2_d;
			v3_q <= v3_d;
		end
	end

	function automatic logic [14:0] coord(input logic [31:0] v);
		logic [31:0] m;
		m = v - 32'd1;
		if (v == 32'd0) return 15'd0;
		if (m > 32'h7fff) return 15'h7fff;
		return m[14:0];
	endfunction

	function automatic logic [31:0] mac10(input logic [31:0] v, input logic [7:0] b);
		logic [31:0] d;
		d = {28'd0, b[3:0]};
		return (v << 3) + (v << 1) + d;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic [31:0] mods;
		logic [2:0]  mm;
		logic [2:0]  low;
		b = byte_s1;
		desc = '0;
		mode_d = mode_q;
		marker_d = marker_q;
		pcnt_d = pcnt_q;
		field_d = field_q;
		sub_d = sub_q;
		mpre_d = mpre_q;
		v1_d = v1_q;
		v2_d = v2_q;
		v3_d = v3_q;
		mods = (v2_q != 32'd0) ? v2_q - 32'd1 : 32'd0;
		mm = (marker_q > 3'd5) ? 3'd0 : marker_q;
		low = {1'b0, v1_q[1:0]};
		case (mode_q)
			M_GROUND: begin
				if (b == B_ESC) begin
					mode_d = M_ESC;
				end else if (b >= 8'h20 && b != 8'h7f) begin
					desc.main_vld = 1'b1;
					desc.kind = K_TEXT;
					desc.text_byte = b;
				end else begin
					desc.main_vld = 1'b1;
					desc.kind = K_KEY;
					if (b == 8'h0d || b == 8'h09 || b == 8'h7f) begin
						desc.key_code = {24'd0, b};
					end else if (b == 8'h00) begin
						desc.key_code = 32'h20;
						desc.modifiers = {29'd0, MOD_CTRL};
					end else if (b <= 8'h1a) begin
						desc.key_code = {24'd0, b + 8'h60};
						desc.modifiers = {29'd0, MOD_CTRL};
					end else begin
						desc.key_code = {24'd0, b | 8'h40};
						desc.modifiers = {29'd0, MOD_CTRL};
					end
				end
			end
			M_ESC: begin
				if (b == 8'h5b) begin
					mode_d = M_CSI;
					pcnt_d = '0;
					field_d = '0;
					sub_d = 1'b0;
					mpre_d = 1'b0;
					v1_d = '0;
					v2_d = '0;
					v3_d = '0;
				end else if (b == 8'h4f) begin
					mode_d = M_SS3;
				end else begin
					mode_d = M_GROUND;
					desc.main_vld = 1'b1;
					desc.kind = K_KEY;
					desc.key_code = {24'd0, b};
					desc.modifiers = {29'd0, MOD_ALT};
				end
			end
			M_CSI: begin
				if (b >= 8'h20 && b <= 8'h3f) begin
					if (pcnt_q >= PCNT_W'(PARAM_CAPACITY)) begin
						mode_d = M_GROUND;
					end else begin
						if (pcnt_q == '0 && b == 8'h3c) mpre_d = 1'b1;
						pcnt_d = pcnt_q + 1'b1;
						if (b == 8'h3b) begin
							if (field_q != 2'd3) field_d = field_q + 2'd1;
							sub_d = 1'b0;
						end else if (b == 8'h3a) begin
							sub_d = 1'b1;
						end else if (b >= 8'h30 && b <= 8'h39 && !sub_q) begin
							case (field_q)
								2'd0: v1_d = mac10(v1_q, b);
								2'd1: v2_d = mac10(v2_q, b);
								2'd2: v3_d = mac10(v3_q, b);
								default: ;
							endcase
						end
					end
				end else if (b >= 8'h40 && b <= 8'h7e) begin
					mode_d = M_GROUND;
					desc.kind = K_KEY;
					desc.modifiers = mods;
					if ((b == 8'h4d || b == 8'h6d) && mpre_q) begin
						desc.main_vld = 1'b1;
						desc.kind = K_MOUSE;
						desc.modifiers = {29'd0, v1_q[4], v1_q[3], v1_q[2]};
						desc.mouse_x = coord(v2_q);
						desc.mouse_y = coord(v3_q);
						if (v1_q[6]) begin
							desc.mouse_button = 3'd4;
							desc.mouse_action = (low == 3'd0) ? 3'd4 : 3'd5;
						end else if (v1_q[5]) begin
							desc.mouse_button = low;
							desc.mouse_action = (low == 3'd3) ? 3'd3 : 3'd2;
						end else begin
							desc.mouse_button = low;
							desc.mouse_action = (b == 8'h4d) ? 3'd0 : 3'd1;
						end
					end else if (b == 8'h75) begin
						desc.main_vld = 1'b1;
						desc.key_code = v1_q;
					end else if (b == 8'h7e) begin
						desc.main_vld = 1'b1;
						if (v1_q == 32'd200) begin
							mode_d = M_PASTE;
							marker_d = '0;
							desc.kind = K_PBEGIN;
							desc.modifiers = '0;
						end else if (v1_q == 32'd27) begin
							desc.key_code = v3_q;
						end else begin
							case (v1_q)
								32'd1, 32'd7: desc.key_code = SK_HOME;
								32'd2: desc.key_code = SK_INSERT;
								32'd3: desc.key_code = SK_DELETE;
								32'd4, 32'd8: desc.key_code = SK_END;
								32'd5: desc.key_code = SK_PGUP;
								32'd6: desc.key_code = SK_PGDN;
								default: desc.main_vld = 1'b0;
							endcase
						end
					end else begin
						desc.main_vld = 1'b1;
						case (b)
							8'h41: desc.key_code = SK_UP;
							8'h42: desc.key_code = SK_DOWN;
							8'h43: desc.key_code = SK_RIGHT;
							8'h44: desc.key_code = SK_LEFT;
							8'h48: desc.key_code = SK_HOME;
							8'h46: desc.key_code = SK_END;
							8'h49: begin
								desc.kind = K_FIN;
								desc.modifiers = '0;
							end
							8'h4f: begin
								desc.kind = K_FOUT;
								desc.modifiers = '0;
							end
							default: desc.main_vld = 1'b0;
						endcase
					end
				end else begin
					mode_d = M_GROUND;
				end
			end
			M_SS3: begin
				mode_d = M_GROUND;
				desc.main_vld = 1'b1;
				desc.kind = K_KEY;
				case (b)
					8'h41: desc.key_code = SK_UP;
					8'h42: desc.key_code = SK_DOWN;
					8'h43: desc.key_code = SK_RIGHT;
					8'h44: desc.key_code = SK_LEFT;
					8'h48: desc.key_code = SK_HOME;
					8'h46: desc.key_code = SK_END;
					default: desc.main_vld = 1'b0;
				endcase
			end
			M_PASTE: begin
				if (b == end_marker(mm)) begin
					if (mm + 3'd1 == MARKER_LEN) begin
						marker_d = '0;
						mode_d = M_GROUND;
						desc.main_vld = 1'b1;
						desc.kind = K_PEND;
					end else begin
						marker_d = mm + 3'd1;
					end
				end else begin
					desc.flush_cnt = mm;
					if (b == B_ESC) begin
						marker_d = 3'd1;
					end else begin
						marker_d = '0;
						desc.main_vld = 1'b1;
						desc.kind = K_PBYTE;
						desc.text_byte = b;
					end
				end
			end
			default: begin
				mode_d = M_GROUND;
			end
		endcase
	end

	assign desc_vld = valid_s1 && (desc.main_vld || desc.flush_cnt != 3'd0);

endmodule

FILE: design/tisd_emitter.sv
// result register that plays out the flushed marker bytes and the main item
module tisd_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_vld,
	input  tisd_pkg::desc_t    desc,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [31:0]        key_code,
	output logic [31:0]        modifiers,
	output logic [7:0]         text_byte,
	output logic [14:0]        mouse_x,
	output logic [14:0]        mouse_y,
	output logic [2:0]         mouse_button,
	output logic [2:0]         mouse_action,
	output logic               last
);
	import tisd_pkg::*;

	desc_t      desc_q;
	logic       vld_q;
	logic [2:0] idx_q;
	logic       in_flush;
	logic       final_item;

	assign in_flush = idx_q < desc_q.flush_cnt;
	assign final_item = in_flush ? (idx_q + 3'd1 == desc_q.flush_cnt) && !desc_q.main_vld
		: 1'b1;
	assign take = !vld_q || (out_ready && final_item);
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			vld_q <= desc_vld;
			idx_q <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && desc_vld) begin
			desc_q <= desc;
		end
	end

	always_comb begin
		last = final_item;
		if (in_flush) begin
			kind = K_PBYTE;
			key_code = '0;
			modifiers = '0;
			text_byte = end_marker(idx_q);
			mouse_x = '0;
			mouse_y = '0;
			mouse_button = '0;
			mouse_action = '0;
		end else begin
			kind = desc_q.kind;
			key_code = desc_q.key_code;
			modifiers = desc_q.modifiers;
			text_byte = desc_q.text_byte;
			mouse_x = desc_q.mouse_x;
			mouse_y = desc_q.mouse_y;
			mouse_button = desc_q.mouse_button;
			mouse_action = desc_q.mouse_action;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> idx_q <= desc_q.flush_cnt)
		else $error("item index ran past flushed bytes");
	a_flush_kind: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && desc_q.flush_cnt != 3'd0 && desc_q.main_vld |-> desc_q.kind == K_PBYTE)
		else $error("flush paired with non paste item");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && kind != K_PBYTE |-> last)
		else $error("non paste item not last");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && in_flush && desc_q.main_vld |-> !last)
		else $error("flushed byte marked last before main item");

endmodule
